>>> hw/rtl/cbmt_pkg.sv
`default_nettype none

package cbmt_pkg;

    // Field widths of one request and one result.
    localparam int TYPE_W = 2;
    localparam int IDX_W  = 4;
    localparam int ELEM_W = 16;
    localparam int SIM_W  = 15;

    // Accumulator widths for squared norms and dot products.
    localparam int NORM_W = 48;
    localparam int ACC_W  = 48;

    // Width of the scoring compare, r*r*qn*sn against dot*dot*2^30.
    localparam int CMP_W = 128;

    // Shift-add multiplier steps and the root search bit counter.
    localparam int MUL_STEPS = NORM_W;
    localparam int MCNT_W    = $clog2(MUL_STEPS);
    localparam int BIT_W     = $clog2(SIM_W);
    localparam int PS_SHIFT  = 2 * (SIM_W - 1);
    localparam int RHS_SHIFT = 2 * SIM_W;

    // Request codes.
    localparam logic [TYPE_W-1:0] REQ_LOAD_REF  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_LOAD_MEAN = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_CLEAR     = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_QUERY     = 2'd3;

    // Threshold after reset, 0.75 in Q0.15.
    localparam logic [SIM_W-1:0] THRESH_RESET = 15'd24576;

endpackage

`default_nettype wire

>>> hw/rtl/cbmt_req_if.sv
`default_nettype none

interface cbmt_req_if import cbmt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [TYPE_W-1:0]        req_type;
    logic [IDX_W-1:0]         entry_index;
    logic signed [ELEM_W-1:0] element_value;
    logic                     last_element;

    modport source (
        output valid, req_type, entry_index, element_value, last_element,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, element_value, last_element,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/cbmt_res_if.sv
`default_nettype none

interface cbmt_res_if import cbmt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SIM_W-1:0] best_score;
    logic             is_match;
    logic             no_references;

    modport source (
        output valid, best_score, is_match, no_references,
        input  ready
    );
    modport sink (
        input  valid, best_score, is_match, no_references,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/cbmt_ram.sv
`default_nettype none

module cbmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cosine_best_match_threshold_core.sv
`default_nettype none

// Channel   Dir  Transfer when         Payload
// i_req     in   valid & ready         req_type, entry_index, element_value, last_element
// o_res     out  valid & ready         best_score, is_match, no_references
// i_cfg     in   i_cfg_we high         i_cfg_data = match_threshold
//
// A load element passes through S_LOAD, and a clear completes in S_IDLE. A query
// element steps through every slot in S_QRD, issuing one vector store read per slot
// that holds an element at the query position through the single read port, and
// then drains the read pipeline. The final query element adds a scoring pass: a slot
// that cannot score is skipped, and one that can runs the two shift-add multipliers
// side by side and then the two-state steps of the root search. S_RESULT loads the result.
// Reset is synchronous and clears lengths, norms, accumulators and flags at once;
// the vector store itself needs no clearing because only written words are read.
// A result waits in the output register while the next request is taken; a new
// result stalls only when that register is still full.

module cosine_best_match_threshold_core import cbmt_pkg::*; #(
    parameter int VECTOR_LEN  = 512,
    parameter int REF_ENTRIES = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [SIM_W-1:0] i_cfg_data,
    cbmt_req_if.sink              i_req,
    cbmt_res_if.source            o_res
);

    // One slot per reference vector plus the mean, which sits in the last slot.
    localparam int NUM_SLOTS = REF_ENTRIES + 1;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int LEN_W     = $clog2(VECTOR_LEN + 2);
    localparam int DEPTH     = NUM_SLOTS * VECTOR_LEN;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int SQ_W      = 2 * ELEM_W;

    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(VECTOR_LEN);
    localparam logic [LEN_W-1:0] LEN_OVER = LEN_W'(VECTOR_LEN + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LOAD    = 4'd1;
    localparam logic [3:0] S_QRD     = 4'd2;
    localparam logic [3:0] S_QDRAIN  = 4'd3;
    localparam logic [3:0] S_SEL     = 4'd4;
    localparam logic [3:0] S_MUL     = 4'd5;
    localparam logic [3:0] S_SQ_INIT = 4'd6;
    localparam logic [3:0] S_SQ_A    = 4'd7;
    localparam logic [3:0] S_SQ_B    = 4'd8;
    localparam logic [3:0] S_UPD     = 4'd9;
    localparam logic [3:0] S_RESULT  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Per-slot bookkeeping and the query accumulators.
    logic [LEN_W-1:0]        r_len  [NUM_SLOTS];
    logic [NORM_W-1:0]       r_norm [NUM_SLOTS];
    logic signed [ACC_W-1:0] r_dot  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]    r_done;
    logic [NORM_W-1:0]       r_qnorm;
    logic [LEN_W-1:0]        r_qcount;
    logic [SIM_W-1:0]        r_thr;

    // The request being worked on.
    logic signed [ELEM_W-1:0] r_val;
    logic                     r_last;
    logic [SLOT_W-1:0]        r_slot;
    logic [ADDR_W-1:0]        r_base;

    // Dot product pipeline: read issue, product, accumulate.
    logic                     r_p1_valid;
    logic [SLOT_W-1:0]        r_p1_slot;
    logic                     r_p2_valid;
    logic [SLOT_W-1:0]        r_p2_slot;
    logic signed [SQ_W-1:0]   r_prod;

    // Scoring unit.
    logic [CMP_W-1:0]  r_pa;
    logic [NORM_W-1:0] r_pb;
    logic [CMP_W-1:0]  r_pacc;
    logic [CMP_W-1:0]  r_ra;
    logic [ACC_W-1:0]  r_rb;
    logic [CMP_W-1:0]  r_racc;
    logic [MCNT_W-1:0] r_mcnt;
    logic [CMP_W-1:0]  r_ps;
    logic [CMP_W-1:0]  r_ms;
    logic [CMP_W-1:0]  r_l;
    logic [CMP_W-1:0]  r_rhs;
    logic [CMP_W-1:0]  r_cand;
    logic [SIM_W-1:0]  r_root;
    logic [BIT_W-1:0]  r_bit;
    logic [SIM_W-1:0]  r_best;

    // Output register.
    logic             r_out_valid;
    logic [SIM_W-1:0] r_out_best;
    logic             r_out_match;
    logic             r_out_noref;

    logic                     req_xfer;
    logic [SLOT_W-1:0]        ld_slot;
    logic [LEN_W-1:0]         ld_len;
    logic [NORM_W-1:0]        ld_norm;
    logic signed [SQ_W-1:0]   sq;
    logic [NORM_W-1:0]        sq_ext;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [ELEM_W-1:0]        ram_rdata;
    logic                     slot_last;
    logic                     eligible;
    logic                     cand_ok;
    logic                     any_stored;
    logic                     out_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_xfer    = i_req.valid && i_req.ready;

    assign ld_slot = (i_req.req_type == REQ_LOAD_MEAN) ? SLOT_W'(REF_ENTRIES)
                                                       : SLOT_W'(i_req.entry_index);

    // A complete entry restarts when a new element arrives for it.
    assign ld_len  = r_done[r_slot] ? '0 : r_len[r_slot];
    assign ld_norm = r_done[r_slot] ? '0 : r_norm[r_slot];
    assign sq      = r_val * r_val;
    assign sq_ext  = {{(NORM_W - SQ_W){1'b0}}, sq};

    assign ram_we    = (r_state == S_LOAD) && (ld_len < LEN_MAX);
    assign ram_waddr = r_base + ADDR_W'(ld_len);
    assign ram_re    = (r_state == S_QRD) && (r_qcount < r_len[r_slot]);
    assign ram_raddr = r_base + ADDR_W'(r_qcount);

    assign slot_last = (r_slot == SLOT_W'(NUM_SLOTS - 1));

    // Only complete entries of the query's length with a positive dot product
    // and nonzero norms can beat the running best; all others score zero.
    assign eligible = r_done[r_slot] && (r_len[r_slot] == r_qcount)
        && (r_qcount <= LEN_MAX) && !r_dot[r_slot][ACC_W-1] && (r_dot[r_slot] != '0)
        && (r_qnorm != '0) && (r_norm[r_slot] != '0);

    assign cand_ok    = (r_cand <= r_rhs);
    assign any_stored = |r_done;
    assign out_free   = !r_out_valid || o_res.ready;

    cbmt_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(r_val),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    unique case (i_req.req_type)
                        REQ_LOAD_REF: begin
                            if (int'(i_req.entry_index) < REF_ENTRIES) begin
                                n_state = S_LOAD;
                            end
                        end
                        REQ_LOAD_MEAN: begin
                            n_state = S_LOAD;
                        end
                        REQ_CLEAR: begin
                            n_state = S_IDLE;
                        end
                        REQ_QUERY: begin
                            if (r_qcount < LEN_MAX) begin
                                n_state = S_QRD;
                            end else if (i_req.last_element) begin
                                n_state = S_SEL;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                n_state = S_IDLE;
            end
            S_QRD: begin
                if (slot_last) begin
                    n_state = S_QDRAIN;
                end
            end
            S_QDRAIN: begin
                if (!r_p1_valid && !r_p2_valid) begin
                    n_state = r_last ? S_SEL : S_IDLE;
                end
            end
            S_SEL: begin
                if (eligible) begin
                    n_state = S_MUL;
                end else if (slot_last) begin
                    n_state = S_RESULT;
                end
            end
            S_MUL: begin
                if (r_mcnt == '0) begin
                    n_state = S_SQ_INIT;
                end
            end
            S_SQ_INIT: begin
                n_state = S_SQ_A;
            end
            S_SQ_A: begin
                n_state = S_SQ_B;
            end
            S_SQ_B: begin
                n_state = (r_bit == '0) ? S_UPD : S_SQ_A;
            end
            S_UPD: begin
                n_state = slot_last ? S_RESULT : S_SEL;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, bookkeeping and the dot product pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= '0;
            r_qnorm     <= '0;
            r_qcount    <= '0;
            r_thr       <= THRESH_RESET;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
            for (int e = 0; e < NUM_SLOTS; e++) begin
                r_len[e]  <= '0;
                r_norm[e] <= '0;
                r_dot[e]  <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end

            r_p1_valid <= ram_re;
            r_p1_slot  <= r_slot;
            r_p2_valid <= r_p1_valid;
            r_p2_slot  <= r_p1_slot;
            r_prod     <= r_val * $signed(ram_rdata);
            if (r_p2_valid) begin
                r_dot[r_p2_slot] <= r_dot[r_p2_slot]
                    + {{(ACC_W - SQ_W){r_prod[SQ_W-1]}}, r_prod};
            end

            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (req_xfer) begin
                        r_val  <= i_req.element_value;
                        r_last <= i_req.last_element;
                        r_slot <= '0;
                        r_base <= '0;
                        unique case (i_req.req_type)
                            REQ_LOAD_REF, REQ_LOAD_MEAN: begin
                                r_slot <= ld_slot;
                                r_base <= ADDR_W'(ld_slot) * ADDR_W'(VECTOR_LEN);
                            end
                            REQ_CLEAR: begin
                                r_done <= '0;
                                for (int e = 0; e < NUM_SLOTS; e++) begin
                                    r_len[e]  <= '0;
                                    r_norm[e] <= '0;
                                end
                            end
                            REQ_QUERY: begin
                                if (r_qcount >= LEN_MAX) begin
                                    r_qcount <= LEN_OVER;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LOAD: begin
                    if (ld_len < LEN_MAX) begin
                        r_len[r_slot]  <= ld_len + LEN_W'(1);
                        r_norm[r_slot] <= ld_norm + sq_ext;
                    end else begin
                        r_len[r_slot]  <= LEN_OVER;
                        r_norm[r_slot] <= ld_norm;
                    end
                    r_done[r_slot] <= r_last;
                end
                S_QRD: begin
                    if (!slot_last) begin
                        r_slot <= r_slot + SLOT_W'(1);
                        r_base <= r_base + ADDR_W'(VECTOR_LEN);
                    end else begin
                        r_slot <= '0;
                    end
                end
                S_QDRAIN: begin
                    if (!r_p1_valid && !r_p2_valid) begin
                        r_qnorm  <= r_qnorm + sq_ext;
                        r_qcount <= r_qcount + LEN_W'(1);
                    end
                end
                S_SEL: begin
                    if (!eligible && !slot_last) begin
                        r_slot <= r_slot + SLOT_W'(1);
                    end
                end
                S_UPD: begin
                    if (r_root > r_best) begin
                        r_best <= r_root;
                    end
                    if (!slot_last) begin
                        r_slot <= r_slot + SLOT_W'(1);
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_best  <= r_best;
                        r_out_match <= any_stored && (r_best >= r_thr);
                        r_out_noref <= !any_stored;
                        r_best      <= '0;
                        r_qnorm     <= '0;
                        r_qcount    <= '0;
                        for (int e = 0; e < NUM_SLOTS; e++) begin
                            r_dot[e] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Scoring datapath. Two shift-add multipliers form qn*sn and dot*dot, then
    // a bit-at-a-time search finds the largest root r with r*r*qn*sn at most
    // dot*dot*2^30. The running terms r*r*P, (r*P) << (b+1) and P << 2b are kept
    // pre-shifted so each step needs only adds, one compare and fixed shifts.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_SEL: begin
                r_pa   <= {{(CMP_W - NORM_W){1'b0}}, r_qnorm};
                r_pb   <= r_norm[r_slot];
                r_pacc <= '0;
                r_ra   <= {{(CMP_W - ACC_W){1'b0}}, r_dot[r_slot]};
                r_rb   <= r_dot[r_slot];
                r_racc <= '0;
                r_mcnt <= MCNT_W'(MUL_STEPS - 1);
            end
            S_MUL: begin
                if (r_pb[0]) begin
                    r_pacc <= r_pacc + r_pa;
                end
                if (r_rb[0]) begin
                    r_racc <= r_racc + r_ra;
                end
                r_pa   <= r_pa << 1;
                r_pb   <= r_pb >> 1;
                r_ra   <= r_ra << 1;
                r_rb   <= r_rb >> 1;
                r_mcnt <= r_mcnt - MCNT_W'(1);
            end
            S_SQ_INIT: begin
                r_ps   <= r_pacc << PS_SHIFT;
                r_ms   <= '0;
                r_l    <= '0;
                r_rhs  <= r_racc << RHS_SHIFT;
                r_root <= '0;
                r_bit  <= BIT_W'(SIM_W - 1);
            end
            S_SQ_A: begin
                r_cand <= r_l + r_ms + r_ps;
            end
            S_SQ_B: begin
                if (cand_ok) begin
                    r_l           <= r_cand;
                    r_ms          <= (r_ms + (r_ps << 1)) >> 1;
                    r_root[r_bit] <= 1'b1;
                end else begin
                    r_ms <= r_ms >> 1;
                end
                r_ps  <= r_ps >> 2;
                r_bit <= r_bit - BIT_W'(1);
            end
            default: ;
        endcase
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.best_score    = r_out_best;
    assign o_res.is_match      = r_out_match;
    assign o_res.no_references = r_out_noref;

endmodule

`default_nettype wire

>>> tb/sv/tb_cosine_best_match_threshold_core.sv
`timescale 1ns / 100ps

module tb_cosine_best_match_threshold_core;
    import cbmt_pkg::*;

    localparam int VLEN   = 512;
    localparam int NREF   = 10;
    localparam int NSLOT  = NREF + 1;
    localparam int SETTLE = 1200;

    typedef struct packed {
        logic [TYPE_W-1:0]        kind;
        logic [IDX_W-1:0]         idx;
        logic signed [ELEM_W-1:0] val;
        logic                     last;
    } req_t;

    typedef struct packed {
        logic [SIM_W-1:0] sim;
        logic             match;
        logic             empty;
    } score_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [SIM_W-1:0] i_cfg_data = '0;

    cbmt_req_if req_if ();
    cbmt_res_if res_if ();

    cosine_best_match_threshold_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Requests waiting to be sent, and scores the block still owes us.
    req_t   pending_reqs[$];
    score_t owed_scores[$];
    int     failures = 0;

    // Predictor state: our own copy of the vector store and accumulators.
    logic signed [15:0] mem_vec[NSLOT][VLEN];
    int unsigned        mem_len[NSLOT];
    logic [47:0]        mem_norm[NSLOT];
    bit                 mem_done[NSLOT];
    logic signed [47:0] dot_acc[NSLOT];
    logic [47:0]        q_norm;
    int unsigned        q_cnt;
    logic [SIM_W-1:0]   thresh;

    // Exact root search: greatest r with r*r*qn*sn <= 2^30*dot*dot.
    function automatic logic [SIM_W-1:0] cos_score(logic signed [47:0] dot,
                                                   logic [47:0] qn, logic [47:0] sn);
        logic [127:0] prod, rhs, lhs, d;
        logic [SIM_W-1:0] r, t;
        if (dot <= 0 || qn == 0 || sn == 0) return '0;
        d    = {80'd0, dot};
        prod = {80'd0, qn} * {80'd0, sn};
        rhs  = (d * d) << 30;
        r    = '0;
        for (int b = SIM_W - 1; b >= 0; b--) begin
            t   = r | (15'd1 << b);
            lhs = prod * ({113'd0, t} * {113'd0, t});
            if (lhs <= rhs) r = t;
        end
        return r;
    endfunction

    task automatic store_element(int e, logic signed [15:0] v, logic last);
        if (mem_done[e]) begin
            mem_len[e]  = 0;
            mem_norm[e] = '0;
            mem_done[e] = 0;
        end
        if (mem_len[e] < VLEN) begin
            mem_vec[e][mem_len[e]] = v;
            mem_norm[e] += 48'(longint'(v) * longint'(v));
            mem_len[e]++;
        end else begin
            mem_len[e] = VLEN + 1;
        end
        if (last) mem_done[e] = 1;
    endtask

    // Applies one accepted request and queues the score it produces, if any.
    task automatic predict_score(req_t r);
        logic [SIM_W-1:0] best, s;
        bit any;
        score_t res;
        longint qv;
        best = '0;
        any  = 0;
        qv   = longint'($signed(r.val));
        case (r.kind)
            REQ_LOAD_REF: begin
                if (r.idx < NREF) store_element(int'(r.idx), r.val, r.last);
            end
            REQ_LOAD_MEAN: store_element(NREF, r.val, r.last);
            REQ_CLEAR: begin
                for (int e = 0; e < NSLOT; e++) begin
                    mem_len[e]  = 0;
                    mem_norm[e] = '0;
                    mem_done[e] = 0;
                end
            end
            default: begin
                if (q_cnt < VLEN) begin
                    for (int e = 0; e < NSLOT; e++)
                        if (q_cnt < mem_len[e])
                            dot_acc[e] += 48'(qv * longint'(mem_vec[e][q_cnt]));
                    q_norm += 48'(qv * qv);
                    q_cnt++;
                end else begin
                    q_cnt = VLEN + 1;
                end
                if (r.last) begin
                    // The mean sits in the last slot, so it is checked last.
                    for (int e = 0; e < NSLOT; e++) begin
                        if (mem_done[e]) begin
                            any = 1;
                            if (mem_len[e] == q_cnt && q_cnt <= VLEN) begin
                                s = cos_score(dot_acc[e], q_norm, mem_norm[e]);
                                if (s > best) best = s;
                            end
                        end
                    end
                    res.sim   = best;
                    res.match = any && (best >= thresh);
                    res.empty = !any;
                    owed_scores.insert(owed_scores.size(), res);
                    for (int e = 0; e < NSLOT; e++) dot_acc[e] = '0;
                    q_norm = '0;
                    q_cnt  = 0;
                end
            end
        endcase
    endtask

    // Driver: sends pending requests in bursts separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin : driver
        req_t nxt;
        bit accepted;
        accepted = req_if.valid && req_if.ready;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (accepted) predict_score({req_if.req_type, req_if.entry_index,
                                         req_if.element_value, req_if.last_element});
            if (!req_if.valid || accepted) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    nxt = pending_reqs.pop_front();
                    req_if.req_type      <= nxt.kind;
                    req_if.entry_index   <= nxt.idx;
                    req_if.element_value <= nxt.val;
                    req_if.last_element  <= nxt.last;
                    req_if.valid         <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: the receiver stalls in runs whose density changes over time.
    int stall_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge i_clk) begin : monitor
        score_t got, want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = {res_if.best_score, res_if.is_match, res_if.no_references};
                if (owed_scores.size() == 0) begin
                    $display("%0t: unexpected transfer, actual sim=%0d match=%0b empty=%0b",
                             $time, got.sim, got.match, got.empty);
                    failures++;
                end else begin
                    want = owed_scores.pop_front();
                    if (got.sim !== want.sim) begin
                        $display("%0t: best_score expected %0d actual %0d",
                                 $time, want.sim, got.sim);
                        failures++;
                    end
                    if (got.match !== want.match) begin
                        $display("%0t: is_match expected %0b actual %0b",
                                 $time, want.match, got.match);
                        failures++;
                    end
                    if (got.empty !== want.empty) begin
                        $display("%0t: no_references expected %0b actual %0b",
                                 $time, want.empty, got.empty);
                        failures++;
                    end
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(50, 800);
            end else begin
                mode_left--;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if (stall_mode == 1 && $urandom_range(0, 3) == 0)
                    stall_left = $urandom_range(1, 5);
                else if (stall_mode == 2 && $urandom_range(0, 1) == 0)
                    stall_left = $urandom_range(1, 60);
            end
        end
    end

    // Stimulus-side copy of the vectors loaded so far, used to build queries
    // that resemble stored entries so that high scores actually occur.
    int gen_vec[NSLOT][$];
    bit gen_ok[NSLOT];
    int sent = 0;

    task automatic push_req(logic [TYPE_W-1:0] kind, int idx, int val, bit last);
        req_t r;
        r.kind = kind;
        r.idx  = idx[IDX_W-1:0];
        r.val  = val[15:0];
        r.last = last;
        pending_reqs.insert(pending_reqs.size(), r);
        if (kind != REQ_LOAD_REF || idx < NREF) sent++;
    endtask

    task automatic push_vector(logic [TYPE_W-1:0] kind, int idx, int vals[$], bit close);
        int slot;
        slot = (kind == REQ_LOAD_MEAN) ? NREF : idx;
        foreach (vals[i]) push_req(kind, idx, vals[i], close && (i == vals.size() - 1));
        if (kind != REQ_QUERY && slot < NSLOT) begin
            gen_vec[slot] = vals;
            gen_ok[slot]  = close;
        end
    endtask

    function automatic int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic random_vector(int len, ref int vals[$]);
        int span;
        vals.delete();
        span = ($urandom_range(0, 3) == 0) ? 32768 : $urandom_range(1, 3000);
        for (int i = 0; i < len; i++)
            vals.insert(vals.size(), clamp16($signed($urandom_range(0, 2 * span)) - span));
    endtask

    // Query derived from a stored entry: exact, scaled, noisy, negated or unrelated.
    task automatic push_query(int len);
        int vals[$];
        int cand[$];
        int src, how, v;
        for (int e = 0; e < NSLOT; e++) if (gen_ok[e]) cand.insert(cand.size(), e);
        how = $urandom_range(0, 5);
        if (cand.size() == 0 || how == 5) begin
            random_vector(len, vals);
        end else begin
            src = cand[$urandom_range(0, cand.size() - 1)];
            foreach (gen_vec[src][i]) begin
                case (how)
                    0: v = gen_vec[src][i];
                    1: v = gen_vec[src][i] / 2;
                    2: v = clamp16(gen_vec[src][i] + $urandom_range(0, 200) - 100);
                    3: v = clamp16(-gen_vec[src][i]);
                    default: v = clamp16(gen_vec[src][i] + $urandom_range(0, 4000) - 2000);
                endcase
                vals.insert(vals.size(), v);
            end
        end
        push_vector(REQ_QUERY, 0, vals, 1);
    endtask

    task automatic random_phase(int target);
        int vals[$];
        int len, pick, stop;
        len  = $urandom_range(1, 6);
        stop = sent + target;
        while (sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                random_vector(($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : len, vals);
                push_vector(REQ_LOAD_REF, $urandom_range(0, NREF - 1), vals,
                            $urandom_range(0, 9) != 0);
            end else if (pick < 42) begin
                random_vector(len, vals);
                push_vector(REQ_LOAD_MEAN, 0, vals, 1);
            end else if (pick < 85) begin
                push_query(len);
            end else if (pick < 88) begin
                push_req(REQ_CLEAR, $urandom_range(0, 15), $urandom, $urandom_range(0, 1));
                foreach (gen_ok[e]) gen_ok[e] = 0;
            end else if (pick < 92) begin
                // Out-of-range entry index; the block drops these.
                push_req(REQ_LOAD_REF, $urandom_range(NREF, 15), $urandom, $urandom_range(0, 1));
            end else begin
                random_vector($urandom_range(1, 8), vals);
                push_vector(REQ_QUERY, 0, vals, 1);
            end
        end
    endtask

    // Waits until every request is sent and every score has arrived, then lets
    // a trailing load or scoring pass finish before the block counts as idle.
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || req_if.valid || owed_scores.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [SIM_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        thresh = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int vals[$];
        req_if.valid         = 1'b0;
        req_if.req_type      = REQ_LOAD_REF;
        req_if.entry_index   = '0;
        req_if.element_value = '0;
        req_if.last_element  = 1'b0;
        res_if.ready         = 1'b0;
        thresh               = THRESH_RESET;
        q_norm               = '0;
        q_cnt                = 0;
        for (int e = 0; e < NSLOT; e++) begin
            mem_len[e]  = 0;
            mem_norm[e] = '0;
            mem_done[e] = 0;
            dot_acc[e]  = '0;
            gen_ok[e]   = 0;
            for (int i = 0; i < VLEN; i++) mem_vec[e][i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset threshold.
        push_vector(REQ_QUERY, 0, {3, -7}, 1);                 // nothing stored yet
        push_vector(REQ_LOAD_REF, 0, {32767, -32768}, 1);
        push_vector(REQ_LOAD_REF, 9, {1, 0}, 1);
        push_req(REQ_LOAD_REF, 12, 555, 1);                    // index out of range
        push_vector(REQ_LOAD_MEAN, 0, {-32768, 32767}, 1);
        push_vector(REQ_QUERY, 0, {32767, -32768}, 1);         // near-perfect match
        push_vector(REQ_QUERY, 0, {0, 0}, 1);                  // zero query norm
        push_vector(REQ_LOAD_REF, 3, {5}, 0);                  // left incomplete
        push_vector(REQ_QUERY, 0, {-1, 0}, 1);                 // negative dot but for the mean
        push_req(REQ_CLEAR, 0, 0, 0);
        push_vector(REQ_QUERY, 0, {9}, 1);                     // cleared store
        push_vector(REQ_LOAD_REF, 1, {3, 4}, 1);
        push_vector(REQ_LOAD_REF, 1, {4, 3}, 1);               // reload restarts entry
        push_vector(REQ_QUERY, 0, {4, 3}, 1);
        push_vector(REQ_QUERY, 0, {4}, 1);                     // length mismatch
        wait_idle();

        write_threshold(15'd0);
        random_phase(90);
        wait_idle();
        write_threshold(15'd32767);
        random_phase(90);
        wait_idle();
        write_threshold(15'($urandom_range(16000, 32767)));
        random_phase(90);
        wait_idle();
        write_threshold(15'($urandom_range(1, 16000)));
        random_phase(90);
        wait_idle();

        // A stored vector and a query one past the maximum length: every store address
        // of slot 4 is written and read, and equal overlong lengths never match.
        write_threshold(THRESH_RESET);
        push_req(REQ_CLEAR, 0, 0, 0);
        random_vector(VLEN + 1, vals);
        push_vector(REQ_LOAD_REF, 4, vals, 1);
        push_vector(REQ_QUERY, 0, vals, 1);
        wait_idle();

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(64'd100_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> cosine_best_match_threshold_core.f
hw/rtl/cbmt_pkg.sv
hw/rtl/cbmt_req_if.sv
hw/rtl/cbmt_res_if.sv
hw/rtl/cbmt_ram.sv
hw/rtl/cosine_best_match_threshold_core.sv
tb/sv/tb_cosine_best_match_threshold_core.sv
